### design/prime_field_matrix_row_ops_unit_assert.svh
// assertion macros shared by the matrix row operation unit
// no dependencies; included by the modules that carry checks
`ifndef PRIME_FIELD_MATRIX_ROW_OPS_UNIT_ASSERT_SVH
`define PRIME_FIELD_MATRIX_ROW_OPS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PFMR_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define PFMR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define PFMR_ASSERT(lbl, ck, rn, prop, msg)
`define PFMR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

### design/pfmr_pkg.sv
// shared types and constants of the matrix row operation unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pfmr_pkg;

  localparam int DW = 16;

  // width of one stored matrix entry
  localparam int ELEMENT_BITS = 16;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_IDENT = 3'd2,
    ACT_SWAP  = 3'd3,
    ACT_SUB   = 3'd4,
    ACT_DIV   = 3'd5,
    ACT_TRANS = 3'd6,
    ACT_NONE  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOINV = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // command to the shared modular unit
  typedef struct packed {
    logic          start;
    logic          mulmod;
    logic [DW-1:0] x;
    logic [DW-1:0] addend;
    logic [DW-1:0] m;
  } mu_cmd_t;

  // status of the shared modular unit
  typedef struct packed {
    logic          busy;
    logic [DW-1:0] res;
    logic [DW-1:0] quot;
  } mu_stat_t;

endpackage
`default_nettype wire

### design/prime_field_matrix_row_ops_unit.sv
// top level: matrix store over the prime field with elementary row operations
// depends on pfmr_pkg, pfmr_mod_unit and prime_field_matrix_row_ops_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "prime_field_matrix_row_ops_unit_assert.svh"

// Holds one square matrix mod p in an on-chip memory and runs one operation per
// input transaction, one result transaction each. One item at a time: in_tready
// is high only when the sequencer is idle; a finished result sits in the output
// register so the next item can enter while it waits. Identity and the clearing
// pass sweep every entry of the store; swap and transpose exchange entries pair by
// pair; subtract and divide walk row_a column by column, and divide first finds the
// inverse by Euclid rounds (at most about 24 rounds). Arithmetic time is set by the
// shared bit-serial modular unit (16 steps per reduction, multiply or division);
// swaps and sweeps by the single memory write port.
// After reset a clearing pass over the whole store runs before the
// first item is taken; configuration writes are taken at any time.
module prime_field_matrix_row_ops_unit #(
  parameter int MAX_DIM      = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // action, row_a, row_b_or_column, value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // read_value, status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,  // 0 modulus, 1 size_in_use
  input  wire logic [15:0] cfg_data
);

  localparam int DW    = pfmr_pkg::DW;
  localparam int RW    = $clog2(MAX_DIM);
  localparam int AW    = 2 * RW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int EB    = pfmr_pkg::ELEMENT_BITS;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_SWEEP, S_RD_DATA,
    S_SW_RDA, S_SW_RDB, S_SW_WA, S_SW_WB,
    S_SB_VSAVE, S_SB_RDB, S_SB_RB, S_SB_MUL, S_SB_RDA, S_SB_RA, S_SB_WR,
    S_EU_INIT, S_EU_TEST, S_EU_Q, S_EU_UPD,
    S_DV_RD, S_DV_RA, S_DV_MUL, S_DV_WR,
    S_WAIT, S_FIN
  } state_t;

  // configuration
  logic [15:0] modulus_r;
  logic [4:0]  size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= 16'd65521;
      size_r    <= 5'd16;
    end else if (cfg_valid) begin
      if (cfg_index) begin
        size_r <= cfg_data[4:0];
      end else begin
        modulus_r <= cfg_data;
      end
    end
  end
  assign cfg_ready = 1'b1;

  logic [DW-1:0] p_eff;
  logic [NW-1:0] n_eff;
  assign p_eff = (modulus_r == '0) ? DW'(1) : modulus_r;
  assign n_eff = (8'(size_r) > 8'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(size_r);

  // sequencer registers
  state_t            state_r, state_nxt, ret_r, ret_nxt;
  pfmr_pkg::action_t act_r, act_nxt;
  logic [3:0]        ra_r, ra_nxt, rb_r, rb_nxt;
  logic [DW-1:0]     val_r, val_nxt;
  logic [NW-1:0]     i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0]     sweep_r, sweep_nxt;
  logic [EB-1:0]     tmp_r, tmp_nxt;
  logic [DW-1:0]     mop_r, mop_nxt;     // multiplier operand: value mod p or inverse
  logic [DW-1:0]     prod_r, prod_nxt;
  logic [DW-1:0]     oldr_r, oldr_nxt, r_r, r_nxt, rem_r, rem_nxt;
  logic [DW-1:0]     olds_r, olds_nxt, s_r, s_nxt;
  logic [DW-1:0]     rd_r, rd_nxt;
  pfmr_pkg::status_t st_r, st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DW-1:0]     out_rd_r, out_rd_nxt;
  pfmr_pkg::status_t out_st_r, out_st_nxt;

  // memory port signals
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EB-1:0] wdata;
  logic [EB-1:0] rdata_r;
  logic [EB-1:0] mem [DEPTH];

  pfmr_pkg::mu_cmd_t  ucmd;
  pfmr_pkg::mu_stat_t ustat;

  pfmr_mod_unit u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (ucmd),
    .stat (ustat)
  );

  // (a - t) mod p with both operands already below p
  function automatic logic [DW-1:0] submod(input logic [DW-1:0] a,
                                           input logic [DW-1:0] t,
                                           input logic [DW-1:0] p);
    logic [DW-1:0] d;
    d = a - t;
    return (a >= t) ? d : d + p;
  endfunction

  logic [RW-1:0] rowa, rowb, ic, jc;
  logic [AW-1:0] addr_a, addr_b;
  logic          trans, idx_ok, ra_ok, col_more, i_more, diag;

  always_comb begin
    rowa     = RW'(ra_r);
    rowb     = RW'(rb_r);
    ic       = i_r[RW-1:0];
    jc       = j_r[RW-1:0];
    trans    = (act_r == pfmr_pkg::ACT_TRANS);
    addr_a   = trans ? {ic, jc} : {rowa, jc};
    addr_b   = trans ? {jc, ic} : {rowb, jc};
    ra_ok    = 8'(ra_r) < 8'(n_eff);
    idx_ok   = ra_ok && (8'(rb_r) < 8'(n_eff));
    col_more = (8'(j_r) + 8'd1) < 8'(n_eff);
    i_more   = (8'(i_r) + 8'd2) < 8'(n_eff);
    diag     = (sweep_r[AW-1:RW] == sweep_r[RW-1:0]) &&
               (8'(sweep_r[AW-1:RW]) < 8'(n_eff));
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    act_nxt       = act_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    val_nxt       = val_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    sweep_nxt     = sweep_r;
    tmp_nxt       = tmp_r;
    mop_nxt       = mop_r;
    prod_nxt      = prod_r;
    oldr_nxt      = oldr_r;
    r_nxt         = r_r;
    rem_nxt       = rem_r;
    olds_nxt      = olds_r;
    s_nxt         = s_r;
    rd_nxt        = rd_r;
    st_nxt        = st_r;
    out_rd_nxt    = out_rd_r;
    out_st_nxt    = out_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    we            = 1'b0;
    waddr         = addr_a;
    wdata         = '0;
    raddr         = addr_a;
    ucmd.start    = 1'b0;
    ucmd.mulmod   = 1'b0;
    ucmd.x        = '0;
    ucmd.addend   = '0;
    ucmd.m        = p_eff;

    case (state_r)
      S_CLEAR: begin
        we        = 1'b1;
        waddr     = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = pfmr_pkg::action_t'(in_tdata[2:0]);
          ra_nxt    = in_tdata[6:3];
          rb_nxt    = in_tdata[10:7];
          val_nxt   = in_tdata[26:11];
          rd_nxt    = '0;
          st_nxt    = pfmr_pkg::ST_OK;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        i_nxt     = '0;
        j_nxt     = '0;
        state_nxt = S_FIN;
        case (act_r)
          pfmr_pkg::ACT_WRITE: begin
            if (idx_ok) begin
              we    = 1'b1;
              waddr = {rowa, rowb};
              wdata = EB'(val_r);
            end else begin
              st_nxt = pfmr_pkg::ST_RANGE;
            end
          end
          pfmr_pkg::ACT_READ: begin
            raddr = {rowa, rowb};
            if (idx_ok) begin
              state_nxt = S_RD_DATA;
            end else begin
              st_nxt = pfmr_pkg::ST_RANGE;
            end
          end
          pfmr_pkg::ACT_IDENT: begin
            sweep_nxt = '0;
            state_nxt = S_SWEEP;
          end
          pfmr_pkg::ACT_SWAP: begin
            if (idx_ok) begin
              state_nxt = S_SW_RDA;
            end else begin
              st_nxt = pfmr_pkg::ST_RANGE;
            end
          end
          pfmr_pkg::ACT_SUB: begin
            if (idx_ok) begin
              ucmd.start = 1'b1;
              ucmd.x     = val_r;
              ret_nxt    = S_SB_VSAVE;
              state_nxt  = S_WAIT;
            end else begin
              st_nxt = pfmr_pkg::ST_RANGE;
            end
          end
          pfmr_pkg::ACT_DIV: begin
            if (ra_ok) begin
              ucmd.start = 1'b1;
              ucmd.x     = val_r;
              ret_nxt    = S_EU_INIT;
              state_nxt  = S_WAIT;
            end else begin
              st_nxt = pfmr_pkg::ST_RANGE;
            end
          end
          pfmr_pkg::ACT_TRANS: begin
            // upper triangle pairs start at (0,1)
            j_nxt = NW'(1);
            if (8'(n_eff) >= 8'd2) begin
              state_nxt = S_SW_RDA;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SWEEP: begin
        we        = 1'b1;
        waddr     = sweep_r;
        wdata     = diag ? EB'(1) : '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) begin
          state_nxt = S_FIN;
        end
      end
      S_RD_DATA: begin
        rd_nxt    = DW'(rdata_r);
        state_nxt = S_FIN;
      end
      // swap of two entries, shared by row swap and transpose
      S_SW_RDA: begin
        raddr     = addr_a;
        state_nxt = S_SW_RDB;
      end
      S_SW_RDB: begin
        raddr     = addr_b;
        tmp_nxt   = rdata_r;
        state_nxt = S_SW_WA;
      end
      S_SW_WA: begin
        we        = 1'b1;
        waddr     = addr_a;
        wdata     = rdata_r;
        state_nxt = S_SW_WB;
      end
      S_SW_WB: begin
        we        = 1'b1;
        waddr     = addr_b;
        wdata     = tmp_r;
        state_nxt = S_FIN;
        if (col_more) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_SW_RDA;
        end else if (trans && i_more) begin
          i_nxt     = i_r + 1'b1;
          j_nxt     = NW'(8'(i_r) + 8'd2);
          state_nxt = S_SW_RDA;
        end
      end
      // row_a -= value * row_b, column by column
      S_SB_VSAVE: begin
        mop_nxt   = ustat.res;
        state_nxt = S_SB_RDB;
      end
      S_SB_RDB: begin
        raddr     = addr_b;
        state_nxt = S_SB_RB;
      end
      S_SB_RB: begin
        ucmd.start = 1'b1;
        ucmd.x     = DW'(rdata_r);
        ret_nxt    = S_SB_MUL;
        state_nxt  = S_WAIT;
      end
      S_SB_MUL: begin
        ucmd.start  = 1'b1;
        ucmd.mulmod = 1'b1;
        ucmd.x      = ustat.res;
        ucmd.addend = mop_r;
        ret_nxt     = S_SB_RDA;
        state_nxt   = S_WAIT;
      end
      S_SB_RDA: begin
        prod_nxt  = ustat.res;
        raddr     = addr_a;
        state_nxt = S_SB_RA;
      end
      S_SB_RA: begin
        ucmd.start = 1'b1;
        ucmd.x     = DW'(rdata_r);
        ret_nxt    = S_SB_WR;
        state_nxt  = S_WAIT;
      end
      S_SB_WR: begin
        we        = 1'b1;
        waddr     = addr_a;
        wdata     = EB'(submod(ustat.res, prod_r, p_eff));
        state_nxt = S_FIN;
        if (col_more) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_SB_RDB;
        end
      end
      // extended euclid with the cofactor kept mod p
      S_EU_INIT: begin
        oldr_nxt  = ustat.res;
        r_nxt     = p_eff;
        olds_nxt  = DW'(1);
        s_nxt     = '0;
        state_nxt = S_EU_TEST;
      end
      S_EU_TEST: begin
        if (r_r == '0) begin
          if (oldr_r == DW'(1) && p_eff >= DW'(2)) begin
            mop_nxt   = olds_r;
            state_nxt = S_DV_RD;
          end else begin
            st_nxt    = pfmr_pkg::ST_NOINV;
            state_nxt = S_FIN;
          end
        end else begin
          ucmd.start = 1'b1;
          ucmd.x     = oldr_r;
          ucmd.m     = r_r;
          ret_nxt    = S_EU_Q;
          state_nxt  = S_WAIT;
        end
      end
      S_EU_Q: begin
        rem_nxt     = ustat.res;
        ucmd.start  = 1'b1;
        ucmd.mulmod = 1'b1;
        ucmd.x      = ustat.quot;
        ucmd.addend = s_r;
        ret_nxt     = S_EU_UPD;
        state_nxt   = S_WAIT;
      end
      S_EU_UPD: begin
        oldr_nxt  = r_r;
        r_nxt     = rem_r;
        olds_nxt  = s_r;
        s_nxt     = submod(olds_r, ustat.res, p_eff);
        state_nxt = S_EU_TEST;
      end
      // row_a *= inverse, column by column
      S_DV_RD: begin
        raddr     = addr_a;
        state_nxt = S_DV_RA;
      end
      S_DV_RA: begin
        ucmd.start = 1'b1;
        ucmd.x     = DW'(rdata_r);
        ret_nxt    = S_DV_MUL;
        state_nxt  = S_WAIT;
      end
      S_DV_MUL: begin
        ucmd.start  = 1'b1;
        ucmd.mulmod = 1'b1;
        ucmd.x      = ustat.res;
        ucmd.addend = mop_r;
        ret_nxt     = S_DV_WR;
        state_nxt   = S_WAIT;
      end
      S_DV_WR: begin
        we        = 1'b1;
        waddr     = addr_a;
        wdata     = EB'(ustat.res);
        state_nxt = S_FIN;
        if (col_more) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_DV_RD;
        end
      end
      S_WAIT: begin
        if (!ustat.busy) begin
          state_nxt = ret_r;
        end
      end
      S_FIN: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ret_r    <= ret_nxt;
    act_r    <= act_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    val_r    <= val_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    tmp_r    <= tmp_nxt;
    mop_r    <= mop_nxt;
    prod_r   <= prod_nxt;
    oldr_r   <= oldr_nxt;
    r_r      <= r_nxt;
    rem_r    <= rem_nxt;
    olds_r   <= olds_nxt;
    s_r      <= s_nxt;
    rd_r     <= rd_nxt;
    st_r     <= st_nxt;
    out_rd_r <= out_rd_nxt;
    out_st_r <= out_st_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // matrix store, row-major with a power-of-two stride
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_st_r, out_rd_r};

  `PFMR_ASSERT(a_accept_unit_idle, clk, rst_n, (in_tvalid && in_tready) |-> !ustat.busy, "item accepted while modular unit busy")
  `PFMR_ASSERT(a_no_write_when_idle, clk, rst_n, (state_r == S_IDLE) |-> !we, "store written while idle")
  `PFMR_ASSERT(a_unit_start_free, clk, rst_n, ucmd.start |-> !ustat.busy, "modular unit restarted while busy")
  `PFMR_ASSERT(a_status_code, clk, rst_n, out_valid_r |-> (out_st_r == pfmr_pkg::ST_OK || out_st_r == pfmr_pkg::ST_NOINV || out_st_r == pfmr_pkg::ST_RANGE), "bad status code")
  `PFMR_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "second item taken while first in progress")

endmodule
`default_nettype wire

### design/pfmr_mod_unit.sv
// bit-serial modular unit: reduction, division with quotient, modular multiply
// depends on pfmr_pkg
`timescale 1ns / 1ps
`default_nettype none
module pfmr_mod_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pfmr_pkg::mu_cmd_t  cmd,
  output pfmr_pkg::mu_stat_t      stat
);

  localparam int DW = pfmr_pkg::DW;
  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] acc_r, x_r, q_r, add_r, m_r;
  logic          mul_r;

  logic [DW-1:0] addv;
  logic [DW:0]   t, t2, u, u2;
  logic          w1, w2;

  // one step: acc = (2*acc + addend) mod m, acc kept below m
  always_comb begin
    addv = mul_r ? (x_r[DW-1] ? add_r : '0) : {{(DW-1){1'b0}}, x_r[DW-1]};
    t    = {acc_r, 1'b0};
    w1   = t >= {1'b0, m_r};
    t2   = w1 ? t - {1'b0, m_r} : t;
    u    = t2 + {1'b0, addv};
    w2   = u >= {1'b0, m_r};
    u2   = w2 ? u - {1'b0, m_r} : u;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
      q_r   <= '0;
      x_r   <= cmd.x;
      add_r <= cmd.addend;
      m_r   <= cmd.m;
      mul_r <= cmd.mulmod;
    end else if (busy_r) begin
      acc_r <= u2[DW-1:0];
      x_r   <= {x_r[DW-2:0], 1'b0};
      q_r   <= {q_r[DW-2:0], w1 | w2};
    end
  end

  assign stat.busy = busy_r;
  assign stat.res  = acc_r;
  assign stat.quot = q_r;

endmodule
`default_nettype wire
